// ----- hdl/imm_pkg.sv -----
`default_nettype none

package imm_pkg;

   // Configuration port
   localparam int CFG_W       = 4;
   localparam int CSR_INDEX_W = 2;

   localparam logic [CSR_INDEX_W-1:0] REG_ROWS_A    = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_INNER_LEN = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] REG_COLS_B    = 2'd2;

   localparam logic [CFG_W-1:0] CFG_RESET = 4'd8;

   // Result fields
   localparam int ACC_W     = 35;
   localparam int OUT_IDX_W = 3;

   typedef enum logic [2:0] {
      ST_LOAD,
      ST_MAC,
      ST_DRAIN_MUL,
      ST_DRAIN_ACC,
      ST_OUT
   } state_type;

   typedef struct packed {
      logic wr_a;
      logic wr_b;
      logic issue;
      logic acc_clear;
   } dp_cmd_type;

endpackage

`default_nettype wire

// ----- hdl/imm_datapath.sv -----
`default_nettype none

module imm_datapath import imm_pkg::*; #(
   parameter int MAX_DIM    = 8,
   parameter int ELEM_WIDTH = 16,
   parameter int ADDR_W     = 6
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire dp_cmd_type                    cmd,
   input  wire logic [ADDR_W-1:0]             wr_addr,
   input  wire logic [ELEM_WIDTH-1:0]         wr_data,
   input  wire logic [ADDR_W-1:0]             rd_addr_a,
   input  wire logic [ADDR_W-1:0]             rd_addr_b,
   output logic signed [ACC_W-1:0]            product_value
);

   localparam int DEPTH  = MAX_DIM * MAX_DIM;

   logic [ELEM_WIDTH-1:0] store_a_ff [DEPTH];
   logic [ELEM_WIDTH-1:0] store_b_ff [DEPTH];

   logic signed [ELEM_WIDTH-1:0]   rd_a_ff, rd_b_ff;
   logic                           rd_valid_ff, rd_valid_in;
   logic signed [2*ELEM_WIDTH-1:0] prod_ff, prod_in;
   logic                           prod_valid_ff, prod_valid_in;
   logic signed [ACC_W-1:0]        acc_ff, acc_in;

   // Element stores, registered read
   always_ff @(posedge clock) begin
      if (cmd.wr_a) begin
         store_a_ff[wr_addr] <= wr_data;
      end
      if (cmd.issue) begin
         rd_a_ff <= store_a_ff[rd_addr_a];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.wr_b) begin
         store_b_ff[wr_addr] <= wr_data;
      end
      if (cmd.issue) begin
         rd_b_ff <= store_b_ff[rd_addr_b];
      end
   end

   assign rd_valid_in   = cmd.issue;
   assign prod_valid_in = rd_valid_ff;
   assign prod_in       = rd_a_ff * rd_b_ff;

   always_comb begin
      acc_in = acc_ff;
      if (cmd.acc_clear) begin
         acc_in = '0;
      end else if (prod_valid_ff) begin
         acc_in = acc_ff + ACC_W'(prod_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_valid_ff   <= 1'b0;
         prod_valid_ff <= 1'b0;
         acc_ff        <= '0;
      end else begin
         rd_valid_ff   <= rd_valid_in;
         prod_valid_ff <= prod_valid_in;
         acc_ff        <= acc_in;
      end
   end

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end

   assign product_value = acc_ff;

endmodule

`default_nettype wire

// ----- hdl/imm_ctrl.sv -----
`default_nettype none

module imm_ctrl import imm_pkg::*; #(
   parameter int MAX_DIM = 8,
   parameter int ADDR_W  = 6
) (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    csr_valid,
   input  wire logic [CSR_INDEX_W-1:0]  csr_index,
   input  wire logic [CFG_W-1:0]        csr_data,
   input  wire logic                    req_valid,
   output logic                         req_ready,
   output logic                         rsp_valid,
   input  wire logic                    rsp_ready,
   output logic [OUT_IDX_W-1:0]         rsp_row_index,
   output logic [OUT_IDX_W-1:0]         rsp_col_index,
   output logic                         rsp_last_result,
   output dp_cmd_type                   cmd,
   output logic [ADDR_W-1:0]            wr_addr,
   output logic [ADDR_W-1:0]            rd_addr_a,
   output logic [ADDR_W-1:0]            rd_addr_b
);

   localparam int DEPTH  = MAX_DIM * MAX_DIM;
   localparam int DIM_W  = $clog2(MAX_DIM + 1);
   localparam int IDX_W  = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
   localparam int CNT_W  = $clog2(2 * DEPTH + 1);

   function automatic logic [DIM_W-1:0] clamp_dim(input logic [CFG_W-1:0] v);
      logic [DIM_W-1:0] r;
      if (v == '0) begin
         r = DIM_W'(1);
      end else if (v > CFG_W'(MAX_DIM)) begin
         r = DIM_W'(MAX_DIM);
      end else begin
         r = DIM_W'(v);
      end
      return r;
   endfunction

   state_type state_ff, state_in;

   logic [CFG_W-1:0]  rows_a_ff, rows_a_in;
   logic [CFG_W-1:0]  inner_len_ff, inner_len_in;
   logic [CFG_W-1:0]  cols_b_ff, cols_b_in;
   logic [CNT_W-1:0]  load_count_ff, load_count_in;
   logic [IDX_W-1:0]  i_ff, i_in, j_ff, j_in, t_ff, t_in;
   logic [ADDR_W-1:0] row_base_ff, row_base_in;
   logic [ADDR_W-1:0] tcol_ff, tcol_in;

   logic [DIM_W-1:0]  dim_m, dim_k, dim_n;
   logic [CNT_W-1:0]  size_a, total;
   logic              csr_hit, req_fire, rsp_fire;
   logic              load_last, load_in_a;
   logic              t_last, i_last, j_last, res_last;

   assign dim_m = clamp_dim(rows_a_ff);
   assign dim_k = clamp_dim(inner_len_ff);
   assign dim_n = clamp_dim(cols_b_ff);

   assign size_a = CNT_W'(dim_m) * CNT_W'(dim_k);
   assign total  = size_a + CNT_W'(dim_k) * CNT_W'(dim_n);

   assign csr_hit  = csr_valid && (csr_index == REG_ROWS_A || csr_index == REG_INNER_LEN
                                   || csr_index == REG_COLS_B);
   assign req_fire = req_valid && (state_ff == ST_LOAD);
   assign rsp_fire = rsp_ready && (state_ff == ST_OUT);

   assign load_last = (load_count_ff == total - CNT_W'(1));
   assign load_in_a = (load_count_ff < size_a);

   assign t_last   = (DIM_W'(t_ff) == dim_k - DIM_W'(1));
   assign i_last   = (DIM_W'(i_ff) == dim_m - DIM_W'(1));
   assign j_last   = (DIM_W'(j_ff) == dim_n - DIM_W'(1));
   assign res_last = i_last && j_last;

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_LOAD: begin
            if (req_fire && load_last) begin
               state_in = ST_MAC;
            end
         end
         ST_MAC: begin
            if (t_last) begin
               state_in = ST_DRAIN_MUL;
            end
         end
         ST_DRAIN_MUL: state_in = ST_DRAIN_ACC;
         ST_DRAIN_ACC: state_in = ST_OUT;
         ST_OUT: begin
            if (rsp_fire) begin
               state_in = res_last ? ST_LOAD : ST_MAC;
            end
         end
         default: state_in = ST_LOAD;
      endcase
   end

   // Outputs and commands
   always_comb begin
      req_ready     = 1'b0;
      rsp_valid     = 1'b0;
      cmd           = '0;
      case (state_ff)
         ST_LOAD: begin
            req_ready     = 1'b1;
            cmd.wr_a      = req_fire && load_in_a;
            cmd.wr_b      = req_fire && !load_in_a;
            cmd.acc_clear = req_fire && load_last;
         end
         ST_MAC: begin
            cmd.issue = 1'b1;
         end
         ST_DRAIN_MUL, ST_DRAIN_ACC: begin
         end
         ST_OUT: begin
            rsp_valid     = 1'b1;
            cmd.acc_clear = rsp_fire && !res_last;
         end
         default: begin
         end
      endcase
   end

   assign wr_addr   = load_in_a ? ADDR_W'(load_count_ff) : ADDR_W'(load_count_ff - size_a);
   assign rd_addr_a = row_base_ff + ADDR_W'(t_ff);
   assign rd_addr_b = tcol_ff + ADDR_W'(j_ff);

   assign rsp_row_index   = OUT_IDX_W'(i_ff);
   assign rsp_col_index   = OUT_IDX_W'(j_ff);
   assign rsp_last_result = res_last;

   // Registers, load count and loop counters
   always_comb begin
      rows_a_in     = rows_a_ff;
      inner_len_in  = inner_len_ff;
      cols_b_in     = cols_b_ff;
      load_count_in = load_count_ff;
      i_in          = i_ff;
      j_in          = j_ff;
      t_in          = t_ff;
      row_base_in   = row_base_ff;
      tcol_in       = tcol_ff;

      if (csr_valid && csr_index == REG_ROWS_A) begin
         rows_a_in = csr_data;
      end
      if (csr_valid && csr_index == REG_INNER_LEN) begin
         inner_len_in = csr_data;
      end
      if (csr_valid && csr_index == REG_COLS_B) begin
         cols_b_in = csr_data;
      end

      if (csr_hit) begin
         load_count_in = '0;
      end else if (req_fire) begin
         load_count_in = load_last ? '0 : load_count_ff + CNT_W'(1);
      end

      if (state_ff == ST_MAC) begin
         if (t_last) begin
            t_in    = '0;
            tcol_in = '0;
         end else begin
            t_in    = t_ff + IDX_W'(1);
            tcol_in = tcol_ff + ADDR_W'(dim_n);
         end
      end

      if (rsp_fire) begin
         if (j_last) begin
            j_in = '0;
            if (i_last) begin
               i_in        = '0;
               row_base_in = '0;
            end else begin
               i_in        = i_ff + IDX_W'(1);
               row_base_in = row_base_ff + ADDR_W'(dim_k);
            end
         end else begin
            j_in = j_ff + IDX_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_LOAD;
         rows_a_ff     <= CFG_RESET;
         inner_len_ff  <= CFG_RESET;
         cols_b_ff     <= CFG_RESET;
         load_count_ff <= '0;
         i_ff          <= '0;
         j_ff          <= '0;
         t_ff          <= '0;
         row_base_ff   <= '0;
         tcol_ff       <= '0;
      end else begin
         state_ff      <= state_in;
         rows_a_ff     <= rows_a_in;
         inner_len_ff  <= inner_len_in;
         cols_b_ff     <= cols_b_in;
         load_count_ff <= load_count_in;
         i_ff          <= i_in;
         j_ff          <= j_in;
         t_ff          <= t_in;
         row_base_ff   <= row_base_in;
         tcol_ff       <= tcol_in;
      end
   end

endmodule

`default_nettype wire

// ----- hdl/integer_matrix_multiply.sv -----
// Channel   Direction  Handshake            Payload
// req       in         req_valid/req_ready  req_element (ELEM_WIDTH, signed)
// rsp       out        rsp_valid/rsp_ready  rsp_product_value (35, signed), rsp_row_index,
//                                           rsp_col_index, rsp_last_result
// csr       in         csr_valid/csr_ready  csr_index (2), csr_data (4)
//
// Each element item is stored as it is taken. After the last B element the
// block works out each result on its single multiply-accumulate unit: K store
// reads, then the product and accumulate drain, then the output state, plus any
// wait on rsp_ready. No element item is taken while results are being produced.
// Reset is synchronous and returns all sizes to 8 and the load to A[0][0]; the
// element stores are not cleared.

`default_nettype none

module integer_matrix_multiply import imm_pkg::*; #(
   parameter int MAX_DIM    = 8,
   parameter int ELEM_WIDTH = 16
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   // element items
   input  wire logic                         req_valid,
   output logic                              req_ready,
   input  wire logic signed [ELEM_WIDTH-1:0] req_element,
   // result items
   output logic                              rsp_valid,
   input  wire logic                         rsp_ready,
   output logic signed [ACC_W-1:0]           rsp_product_value,
   output logic [OUT_IDX_W-1:0]              rsp_row_index,
   output logic [OUT_IDX_W-1:0]              rsp_col_index,
   output logic                              rsp_last_result,
   // size registers
   input  wire logic                         csr_valid,
   output logic                              csr_ready,
   input  wire logic [CSR_INDEX_W-1:0]       csr_index,
   input  wire logic [CFG_W-1:0]             csr_data
);

   localparam int DEPTH  = MAX_DIM * MAX_DIM;
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   dp_cmd_type        cmd;
   logic [ADDR_W-1:0] wr_addr;
   logic [ADDR_W-1:0] rd_addr_a;
   logic [ADDR_W-1:0] rd_addr_b;

   // Size writes must arrive only while idle (unenforced here); take them at once
   assign csr_ready = 1'b1;

   // Sequencer: load counting, loop counters, store addresses, handshakes
   imm_ctrl #(
      .MAX_DIM (MAX_DIM),
      .ADDR_W  (ADDR_W)
   ) u_ctrl (
      .clock           (clock),
      .reset           (reset),
      .csr_valid       (csr_valid),
      .csr_index       (csr_index),
      .csr_data        (csr_data),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_row_index   (rsp_row_index),
      .rsp_col_index   (rsp_col_index),
      .rsp_last_result (rsp_last_result),
      .cmd             (cmd),
      .wr_addr         (wr_addr),
      .rd_addr_a       (rd_addr_a),
      .rd_addr_b       (rd_addr_b)
   );

   // Element stores and the multiply-accumulate pipeline
   imm_datapath #(
      .MAX_DIM    (MAX_DIM),
      .ELEM_WIDTH (ELEM_WIDTH),
      .ADDR_W     (ADDR_W)
   ) u_datapath (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .wr_addr       (wr_addr),
      .wr_data       (req_element),
      .rd_addr_a     (rd_addr_a),
      .rd_addr_b     (rd_addr_b),
      .product_value (rsp_product_value)
   );

endmodule

`default_nettype wire

// ----- hdl/imm_checker.sv -----
`default_nettype none

module imm_checker import imm_pkg::*; (
   input wire logic                    clock,
   input wire logic                    reset,
   input wire logic                    req_ready,
   input wire logic                    rsp_valid,
   input wire logic                    rsp_ready,
   input wire logic signed [ACC_W-1:0] rsp_product_value,
   input wire logic [OUT_IDX_W-1:0]    rsp_row_index,
   input wire logic [OUT_IDX_W-1:0]    rsp_col_index,
   input wire logic                    rsp_last_result
);

   // Hold a stalled result item
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_product_value)
         && $stable(rsp_row_index) && $stable(rsp_col_index) && $stable(rsp_last_result))
   else $error("stalled result item changed");

   // Never take an element while a result is on offer
   assert property (@(posedge clock) !(req_ready && rsp_valid))
   else $error("element accepted while results pending");

   // Leave reset ready for A[0][0] with nothing on offer
   assert property (@(posedge clock) reset |=> req_ready && !rsp_valid)
   else $error("wrong state after reset");

   // Drop back to loading after the final result
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && rsp_last_result |=> !rsp_valid && req_ready)
   else $error("no return to loading after final result");

   // Advance to the next result, not to loading, after any other result
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && !rsp_last_result |=> !req_ready)
   else $error("loading resumed before final result");

endmodule

bind integer_matrix_multiply imm_checker u_imm_checker (
   .clock             (clock),
   .reset             (reset),
   .req_ready         (req_ready),
   .rsp_valid         (rsp_valid),
   .rsp_ready         (rsp_ready),
   .rsp_product_value (rsp_product_value),
   .rsp_row_index     (rsp_row_index),
   .rsp_col_index     (rsp_col_index),
   .rsp_last_result   (rsp_last_result)
);

`default_nettype wire

// ----- tb/integer_matrix_multiply_check.sv -----
module integer_matrix_multiply_check import imm_pkg::*; #(
   parameter int ELEM_W = 16
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     req_valid,
   input  wire logic                     req_ready,
   input  wire logic signed [ELEM_W-1:0] req_element,
   input  wire logic                     rsp_valid,
   input  wire logic                     rsp_ready,
   input  wire logic signed [ACC_W-1:0]  rsp_product_value,
   input  wire logic [OUT_IDX_W-1:0]     rsp_row_index,
   input  wire logic [OUT_IDX_W-1:0]     rsp_col_index,
   input  wire logic                     rsp_last_result,
   input  wire logic                     csr_valid,
   input  wire logic                     csr_ready,
   input  wire logic [CSR_INDEX_W-1:0]   csr_index,
   input  wire logic [CFG_W-1:0]         csr_data,
   output int                            mismatch_count,
   output int                            results_awaited
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam int DIM_MAX = 8;

   typedef struct packed {
      logic signed [ACC_W-1:0] value;
      logic [OUT_IDX_W-1:0]    row;
      logic [OUT_IDX_W-1:0]    col;
      logic                    last;
   } product_entry_type;

   product_entry_type       products_due[$];
   product_entry_type       due;
   logic signed [ELEM_W-1:0] a_elems[DIM_MAX*DIM_MAX];
   logic signed [ELEM_W-1:0] b_elems[DIM_MAX*DIM_MAX];
   logic [CFG_W-1:0]        size_reg[3];
   int                      fill_count;

   function automatic int effective_dim(input logic [CFG_W-1:0] raw);
      if (raw == 0) return 1;
      if (raw > DIM_MAX) return DIM_MAX;
      return int'(raw);
   endfunction

   task automatic report_mismatch(input string what);
      $display("[%0t] mismatch: %s", $time, what);
      mismatch_count++;
   endtask

   // Store one element; on the last B element queue the whole product matrix.
   task automatic load_element(input logic signed [ELEM_W-1:0] value);
      int                rows, inner, cols, a_len, total;
      longint            sum;
      product_entry_type entry;
      rows  = effective_dim(size_reg[REG_ROWS_A]);
      inner = effective_dim(size_reg[REG_INNER_LEN]);
      cols  = effective_dim(size_reg[REG_COLS_B]);
      a_len = rows * inner;
      total = a_len + inner * cols;
      if (fill_count >= total) fill_count = 0;
      if (fill_count < a_len) a_elems[fill_count] = value;
      else b_elems[fill_count - a_len] = value;
      fill_count++;
      if (fill_count == total) begin
         for (int i = 0; i < rows; i++) begin
            for (int j = 0; j < cols; j++) begin
               sum = 0;
               for (int t = 0; t < inner; t++)
                  sum += longint'(a_elems[i*inner + t]) * longint'(b_elems[t*cols + j]);
               entry.value = sum[ACC_W-1:0];
               entry.row   = OUT_IDX_W'(i);
               entry.col   = OUT_IDX_W'(j);
               entry.last  = (i == rows - 1) && (j == cols - 1);
               products_due.push_back(entry);
            end
         end
         fill_count = 0;
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         products_due.delete();
         size_reg[REG_ROWS_A]    = CFG_RESET;
         size_reg[REG_INNER_LEN] = CFG_RESET;
         size_reg[REG_COLS_B]    = CFG_RESET;
         fill_count = 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (products_due.size() == 0) begin
               report_mismatch($sformatf("result [%0d][%0d] = %0d with nothing due",
                  rsp_row_index, rsp_col_index, rsp_product_value));
            end else begin
               due = products_due.pop_front();
               if (rsp_product_value !== due.value)
                  report_mismatch($sformatf("[%0d][%0d] value %0d, want %0d",
                     due.row, due.col, rsp_product_value, due.value));
               if (rsp_row_index !== due.row)
                  report_mismatch($sformatf("row index %0d, want %0d", rsp_row_index, due.row));
               if (rsp_col_index !== due.col)
                  report_mismatch($sformatf("col index %0d, want %0d", rsp_col_index, due.col));
               if (rsp_last_result !== due.last)
                  report_mismatch($sformatf("[%0d][%0d] last flag %b, want %b",
                     due.row, due.col, rsp_last_result, due.last));
            end
         end
         // any size write restarts the load; the spare index is ignored
         if (csr_valid && csr_ready) begin
            case (csr_index)
               REG_ROWS_A, REG_INNER_LEN, REG_COLS_B: begin
                  size_reg[csr_index] = csr_data;
                  fill_count = 0;
               end
               default: ;
            endcase
         end
         if (req_valid && req_ready) load_element(req_element);
      end
      results_awaited <= products_due.size();
   end

endmodule

// ----- tb/integer_matrix_multiply_test.sv -----
module integer_matrix_multiply_test;
   timeunit 1ns;
   timeprecision 1ps;

   import imm_pkg::*;

   localparam int ELEM_W         = 16;
   localparam int SETTLE_CYCLES  = 24;    // comfortably above the time one result takes for K = 8
   localparam int HOLDOFF_CYCLES = 500;
   localparam int STALL_LIMIT    = 4000;
   localparam int ITEM_TARGET    = 200;   // random shapes stop once this many items are out

   // index with no register behind it
   localparam logic [CSR_INDEX_W-1:0] REG_UNUSED = 2'd3;

   localparam logic signed [ELEM_W-1:0] ELEM_MIN = 16'sh8000;
   localparam logic signed [ELEM_W-1:0] ELEM_MAX = 16'sh7fff;

   logic                     clock = 1'b0;
   logic                     reset = 1'b1;
   logic                     req_valid = 1'b0;
   logic                     req_ready;
   logic signed [ELEM_W-1:0] req_element = '0;
   logic                     rsp_valid;
   logic                     rsp_ready = 1'b0;
   logic signed [ACC_W-1:0]  rsp_product_value;
   logic [OUT_IDX_W-1:0]     rsp_row_index;
   logic [OUT_IDX_W-1:0]     rsp_col_index;
   logic                     rsp_last_result;
   logic                     csr_valid = 1'b0;
   logic                     csr_ready;
   logic [CSR_INDEX_W-1:0]   csr_index = '0;
   logic [CFG_W-1:0]         csr_data = '0;

   int   mismatch_count;
   int   results_awaited;
   int   items_sent = 0;
   int   idle_cycles = 0;
   logic steady = 1'b0;        // no gaps on either side while set, bar a hold-off
   logic holdoff_req = 1'b0;   // toggle to start a long result stall
   logic holdoff_ack = 1'b0;
   int   rsp_stall_left = 0;
   int   stall_roll;

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   integer_matrix_multiply #(
      .MAX_DIM    (8),
      .ELEM_WIDTH (ELEM_W)
   ) dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_element       (req_element),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_product_value (rsp_product_value),
      .rsp_row_index     (rsp_row_index),
      .rsp_col_index     (rsp_col_index),
      .rsp_last_result   (rsp_last_result),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_index         (csr_index),
      .csr_data          (csr_data)
   );

   integer_matrix_multiply_check #(
      .ELEM_W (ELEM_W)
   ) product_check (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_element       (req_element),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_product_value (rsp_product_value),
      .rsp_row_index     (rsp_row_index),
      .rsp_col_index     (rsp_col_index),
      .rsp_last_result   (rsp_last_result),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_index         (csr_index),
      .csr_data          (csr_data),
      .mismatch_count    (mismatch_count),
      .results_awaited   (results_awaited)
   );

   // Result side: mostly ready, short and occasional long stalls, and one
   // long hold-off on request so that the block backs up into its input.
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
         rsp_stall_left = 0;
      end else if (holdoff_req != holdoff_ack) begin
         holdoff_ack = holdoff_req;
         rsp_stall_left = HOLDOFF_CYCLES - 1;
         rsp_ready <= 1'b0;
      end else if (rsp_stall_left > 0) begin
         rsp_stall_left--;
         rsp_ready <= 1'b0;
      end else if (steady) begin
         rsp_ready <= 1'b1;
      end else begin
         stall_roll = $urandom_range(0, 99);
         if (stall_roll < 70) begin
            rsp_ready <= 1'b1;
         end else begin
            // the current cycle is the first of the stall
            if (stall_roll < 90) rsp_stall_left = $urandom_range(0, 2);
            else if (stall_roll < 98) rsp_stall_left = $urandom_range(3, 9);
            else rsp_stall_left = $urandom_range(20, 60);
            rsp_ready <= 1'b0;
         end
      end
   end

   // Watchdog: end the run if no channel moves an item for too long.
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) ||
          (csr_valid && csr_ready)) begin
         idle_cycles = 0;
      end else begin
         idle_cycles++;
         if (idle_cycles >= STALL_LIMIT) begin
            $display("watchdog: no handshake for %0d cycles", STALL_LIMIT);
            $display("integer_matrix_multiply_test: done, errors");
            $finish;
         end
      end
   end

   function automatic int pick_gap();
      int roll;
      if (steady) return 0;
      roll = $urandom_range(0, 99);
      if (roll < 60) return 0;
      if (roll < 85) return $urandom_range(1, 3);
      if (roll < 97) return $urandom_range(4, 10);
      return $urandom_range(20, 50);
   endfunction

   // Lean on the extremes and on values near zero; the rest is uniform.
   function automatic logic signed [ELEM_W-1:0] pick_element();
      case ($urandom_range(0, 9))
         0: return ELEM_MIN;
         1: return ELEM_MAX;
         2: return ELEM_W'(int'($urandom_range(0, 4)) - 2);
         default: return ELEM_W'($urandom);
      endcase
   endfunction

   function automatic int pick_dim();
      int roll;
      roll = $urandom_range(0, 9);
      if (roll < 6) return $urandom_range(1, 3);
      if (roll < 9) return $urandom_range(4, 7);
      return 8;
   endfunction

   // Write a size now and then as its out-of-range alias: zero for one,
   // anything above eight for eight.
   function automatic logic [CFG_W-1:0] encode_dim(input int dim);
      if (dim == 1 && $urandom_range(0, 3) == 0) return '0;
      if (dim == 8 && $urandom_range(0, 2) == 0) return CFG_W'($urandom_range(9, 15));
      return CFG_W'(dim);
   endfunction

   // Called at a rising edge. Hold valid across back-to-back items; drop it
   // only when a gap is wanted.
   task automatic send_element(input logic signed [ELEM_W-1:0] value);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_element <= value;
      do @(posedge clock); while (!req_ready);
      items_sent++;
   endtask

   task automatic write_reg(input logic [CSR_INDEX_W-1:0] index,
                            input logic [CFG_W-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data  <= data;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   // Drop valid, wait for every due result, then let the block settle.
   task automatic quiesce();
      req_valid <= 1'b0;
      do @(posedge clock); while (results_awaited != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic set_sizes(input int rows, input int inner, input int cols);
      write_reg(REG_ROWS_A, encode_dim(rows));
      write_reg(REG_INNER_LEN, encode_dim(inner));
      write_reg(REG_COLS_B, encode_dim(cols));
      if ($urandom_range(0, 3) == 0) write_reg(REG_UNUSED, CFG_W'($urandom_range(0, 15)));
   endtask

   task automatic send_matrices(input int rows, input int inner, input int cols,
                                input int count);
      repeat (count * (rows * inner + inner * cols)) send_element(pick_element());
   endtask

   initial begin
      int rows, inner, cols;

      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // scalar products at the element extremes
      write_reg(REG_ROWS_A, 4'd1);
      write_reg(REG_INNER_LEN, 4'd1);
      write_reg(REG_COLS_B, 4'd1);
      send_element(ELEM_MIN);
      send_element(ELEM_MIN);
      send_element(ELEM_MAX);
      send_element(ELEM_MIN);
      send_element(ELEM_MAX);
      send_element(ELEM_MAX);
      send_element('0);
      send_element('1);
      quiesce();

      // a write to the spare index must leave a half-loaded pair intact
      send_element(16'sd5);
      quiesce();
      write_reg(REG_UNUSED, 4'hf);
      send_element(-16'sd7);
      quiesce();

      // a size write mid-load drops what was loaded so far
      write_reg(REG_ROWS_A, 4'd2);
      send_element(16'sd100);
      send_element(-16'sd100);
      quiesce();
      write_reg(REG_ROWS_A, 4'd0);
      send_element(16'sd9);
      send_element(16'sd9);
      quiesce();

      // every size zero, acting as one
      write_reg(REG_INNER_LEN, 4'd0);
      write_reg(REG_COLS_B, 4'd0);
      send_element('1);
      send_element(ELEM_MIN);
      quiesce();

      // oversized row count clamps to eight
      write_reg(REG_ROWS_A, 4'd15);
      write_reg(REG_INNER_LEN, 4'd1);
      write_reg(REG_COLS_B, 4'd1);
      for (int i = 0; i < 8; i++) send_element(i[0] ? ELEM_MAX : ELEM_MIN);
      send_element(ELEM_MIN);
      quiesce();

      // Hold results back for a long stretch while three matrices are
      // offered back to back, so the input stalls behind the output.
      steady <= 1'b1;
      set_sizes(2, 2, 2);
      holdoff_req <= ~holdoff_req;
      send_matrices(2, 2, 2, 3);
      quiesce();
      steady <= 1'b0;

      // largest sums of either sign over the full inner length
      set_sizes(1, 8, 1);
      repeat (16) send_element(ELEM_MIN);
      repeat (8) send_element(ELEM_MIN);
      repeat (8) send_element(ELEM_MAX);
      quiesce();

      // the most results one matrix can give
      set_sizes(8, 1, 8);
      send_matrices(8, 1, 8, 1);
      quiesce();

      // random shapes; a few loads are cut short by a size write
      while (items_sent < ITEM_TARGET) begin
         rows  = pick_dim();
         inner = pick_dim();
         cols  = pick_dim();
         steady <= ($urandom_range(0, 3) == 0);
         set_sizes(rows, inner, cols);
         if ($urandom_range(0, 5) == 0) begin
            repeat ($urandom_range(1, rows * inner + inner * cols - 1))
               send_element(pick_element());
            quiesce();
            set_sizes(rows, inner, cols);
         end
         send_matrices(rows, inner, cols, $urandom_range(1, 2));
         quiesce();
      end

      if (mismatch_count == 0 && results_awaited == 0) begin
         $display("integer_matrix_multiply_test: done, clean");
      end else begin
         $display("integer_matrix_multiply_test: done, errors");
      end
      $finish;
   end

endmodule
